// ----- rtl/lcab_pkg.sv -----
`default_nettype none

package lcab_pkg;

  // Operation codes carried by the func field and echoed on done_op.
  typedef enum logic [1:0] {
    OP_TOGGLE  = 2'd0,
    OP_READ    = 2'd1,
    OP_ADVANCE = 2'd2
  } op_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_WRAP    = 2'd0;
  localparam logic [1:0] REG_BIRTH   = 2'd1;
  localparam logic [1:0] REG_SURVIVE = 2'd2;

  localparam int MASK_W  = 9;
  localparam int COORD_W = 6;
  localparam int EXT_W   = 9;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CELL,
    ST_ADV,
    ST_DONE
  } state_t;

  // Rule settings shared by the control and the row update lanes.
  typedef struct packed {
    logic              wrap;
    logic [MASK_W-1:0] birth;
    logic [MASK_W-1:0] survive;
  } rule_cfg_t;

endpackage

`default_nettype wire

// ----- rtl/lcab_board_mem.sv -----
`default_nettype none

module lcab_board_mem #(
  parameter int SIDE = 64,
  parameter int AW   = $clog2(SIDE)
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output      logic [SIDE-1:0] rd_data,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire logic [SIDE-1:0] wr_data
);

  logic [SIDE-1:0] mem [SIDE];
  logic [SIDE-1:0] row_vld;
  logic [SIDE-1:0] rd_q;
  logic            vld_q;

  // A row that was never written since reset reads as all dead.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
    end else if (wr_en) begin
      row_vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q  <= mem[rd_addr];
      vld_q <= row_vld[rd_addr];
    end
  end

  assign rd_data = rd_q & {SIDE{vld_q}};

endmodule

`default_nettype wire

// ----- rtl/lcab_row_rule.sv -----
`default_nettype none

module lcab_row_rule #(
  parameter int SIDE = 64
) (
  input  wire lcab_pkg::rule_cfg_t cfg,
  input  wire logic [SIDE-1:0]     prev_row,
  input  wire logic [SIDE-1:0]     cur_row,
  input  wire logic [SIDE-1:0]     next_row,
  output      logic [SIDE-1:0]     new_row
);

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 4'(v[i]);
    end
    return s;
  endfunction

  // One lane per column; all lanes work on the same three rows at once.
  for (genvar c = 0; c < SIDE; c++) begin : g_lane
    localparam int L      = (c == 0) ? SIDE - 1 : c - 1;
    localparam int R      = (c == SIDE - 1) ? 0 : c + 1;
    localparam bit L_EDGE = (c == 0);
    localparam bit R_EDGE = (c == SIDE - 1);

    logic       lok;
    logic       rok;
    logic [7:0] nb;
    logic [3:0] cnt;

    // Across a side edge a neighbor only counts when the board wraps.
    assign lok = cfg.wrap | ~L_EDGE;
    assign rok = cfg.wrap | ~R_EDGE;
    assign nb  = {prev_row[L] & lok, prev_row[c], prev_row[R] & rok,
                  cur_row[L] & lok, cur_row[R] & rok,
                  next_row[L] & lok, next_row[c], next_row[R] & rok};
    assign cnt = pop8(nb);
    assign new_row[c] = cur_row[c] ? cfg.survive[cnt] : cfg.birth[cnt];
  end

endmodule

`default_nettype wire

// ----- rtl/life_cellular_automaton_board_top.sv -----
// Cellular automaton board of SIDE x SIDE one-bit cells with a programmable
// birth/survive rule. Items arrive on the in channel (func, col_x, row_y) and
// each produces exactly one beat on the out channel (cell_alive, done_op).
// col_x selects a board row and row_y the cell within that row.
// For a toggle or a read, the addressed row is read at the accepting edge,
// then modified and written back in the ST_CELL state, after which the
// output register is loaded from ST_DONE once it is free.
// For an advance, the board memory streams one row per cycle through a
// three-row window, and a row of SIDE parallel lanes computes one new row
// per cycle that is written back in place. The single memory read port
// sets that pace.
// One item is worked on at a time; in_ready is high only while idle. A new
// item may be accepted while the previous result still waits on the output.
// If the receiver stalls, the finished result waits in the block and no new
// item is taken until the output register frees up.
// Reset clears the board (per-row valid bits, no clearing pass), sets bounded
// edges, birth mask 8 and survive mask 12, and empties the output.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once and
// must only be issued while the block is idle.
`default_nettype none

module life_cellular_automaton_board_top #(
  parameter int SIDE = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic [1:0] func,
  input  wire logic [5:0] col_x,
  input  wire logic [5:0] row_y,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      logic       cell_alive,
  output      logic [1:0] done_op,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [8:0] cfg_wdata
);

  localparam int AW = $clog2(SIDE);
  // The advance sequence counts SIDE + 2 steps plus one terminal value.
  localparam int CW = $clog2(SIDE + 3);
  localparam logic [lcab_pkg::EXT_W-1:0] SIDE_EXT = lcab_pkg::EXT_W'(SIDE);

  lcab_pkg::state_t  state;
  lcab_pkg::state_t  state_next;
  lcab_pkg::rule_cfg_t cfg;

  logic                         accept;
  logic [lcab_pkg::EXT_W-1:0]   x_ext;
  logic [lcab_pkg::EXT_W-1:0]   y_ext;
  logic                         in_board;

  logic [1:0]      op_q;
  logic [AW-1:0]   x_q;
  logic [AW-1:0]   y_q;
  logic            in_q;
  logic            res_alive;

  // Advance sequencing: read issue, read arrival, row compute.
  logic [CW-1:0]   issue_cnt;
  logic [CW-1:0]   issue_m1;
  logic            issue_go;
  logic            arr_vld;
  logic            arr_inj;
  logic [CW-1:0]   arr_idx;
  logic [CW-1:0]   arr_m2;
  logic            cmp_vld;
  logic [AW-1:0]   cmp_row;

  logic [SIDE-1:0] win_prev;
  logic [SIDE-1:0] win_cur;
  logic [SIDE-1:0] win_next;
  logic [SIDE-1:0] row0;
  logic [SIDE-1:0] feed;
  logic [SIDE-1:0] new_row;

  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [SIDE-1:0] rd_data;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [SIDE-1:0] wr_data;
  logic            cell_bit;
  logic            out_free;

  assign in_ready = (state == lcab_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign x_ext  = {3'b000, col_x};
  assign y_ext  = {3'b000, row_y};
  assign in_board = (x_ext < SIDE_EXT) && (y_ext < SIDE_EXT);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wrap    <= 1'b0;
      cfg.birth   <= 9'd8;
      cfg.survive <= 9'd12;
    end else if (cfg_we) begin
      case (cfg_index)
        lcab_pkg::REG_WRAP:    cfg.wrap    <= cfg_wdata[0];
        lcab_pkg::REG_BIRTH:   cfg.birth   <= cfg_wdata;
        lcab_pkg::REG_SURVIVE: cfg.survive <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The read stream visits row SIDE-1 first (the row above row 0 on a
  // torus), then rows 0 to SIDE-1, then injects the saved old row 0 as the
  // row below the last one.
  assign issue_go = (state == lcab_pkg::ST_ADV) && (issue_cnt <= CW'(SIDE + 1));
  assign issue_m1 = issue_cnt - CW'(1);
  assign arr_m2   = arr_idx - CW'(2);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = x_ext[AW-1:0];
    if (accept) begin
      rd_en = (func == lcab_pkg::OP_TOGGLE) || (func == lcab_pkg::OP_READ);
    end else if (issue_go) begin
      rd_en   = (issue_cnt <= CW'(SIDE));
      rd_addr = (issue_cnt == '0) ? AW'(SIDE - 1) : issue_m1[AW-1:0];
    end
  end

  // With bounded edges the rows beyond the top and bottom count as dead.
  always_comb begin
    if (arr_inj) begin
      feed = cfg.wrap ? row0 : '0;
    end else if ((arr_idx == '0) && !cfg.wrap) begin
      feed = '0;
    end else begin
      feed = rd_data;
    end
  end

  assign cell_bit = rd_data[y_q];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cmp_row;
    wr_data = new_row;
    if (state == lcab_pkg::ST_CELL) begin
      wr_en   = (op_q == lcab_pkg::OP_TOGGLE) && in_q;
      wr_addr = x_q;
      wr_data = rd_data ^ (SIDE'(1) << y_q);
    end else if (state == lcab_pkg::ST_ADV) begin
      wr_en = cmp_vld;
    end
  end

  lcab_board_mem #(
    .SIDE (SIDE),
    .AW   (AW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  lcab_row_rule #(
    .SIDE (SIDE)
  ) u_rule (
    .cfg      (cfg),
    .prev_row (win_prev),
    .cur_row  (win_cur),
    .next_row (win_next),
    .new_row  (new_row)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcab_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      lcab_pkg::ST_IDLE: begin
        if (accept) begin
          case (func)
            lcab_pkg::OP_TOGGLE,
            lcab_pkg::OP_READ:    state_next = lcab_pkg::ST_CELL;
            lcab_pkg::OP_ADVANCE: state_next = lcab_pkg::ST_ADV;
            default:              state_next = lcab_pkg::ST_DONE;
          endcase
        end
      end
      lcab_pkg::ST_CELL: state_next = lcab_pkg::ST_DONE;
      lcab_pkg::ST_ADV: begin
        if (cmp_vld && (cmp_row == AW'(SIDE - 1))) begin
          state_next = lcab_pkg::ST_DONE;
        end
      end
      lcab_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = lcab_pkg::ST_IDLE;
        end
      end
      default: state_next = lcab_pkg::ST_IDLE;
    endcase
  end

  // Item capture and the toggle/read result.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q      <= func;
      x_q       <= x_ext[AW-1:0];
      y_q       <= y_ext[AW-1:0];
      in_q      <= in_board;
      res_alive <= 1'b0;
    end else if (state == lcab_pkg::ST_CELL) begin
      res_alive <= in_q & (cell_bit ^ (op_q == lcab_pkg::OP_TOGGLE));
    end
  end

  // Advance pipeline control.
  always_ff @(posedge clk) begin
    if (rst) begin
      arr_vld <= 1'b0;
      cmp_vld <= 1'b0;
    end else if (accept) begin
      issue_cnt <= '0;
      arr_vld   <= 1'b0;
      cmp_vld   <= 1'b0;
    end else begin
      if (issue_go) begin
        issue_cnt <= issue_cnt + CW'(1);
      end
      arr_vld <= issue_go;
      arr_inj <= (issue_cnt == CW'(SIDE + 1));
      arr_idx <= issue_cnt;
      cmp_vld <= arr_vld && (arr_idx >= CW'(2));
      cmp_row <= arr_m2[AW-1:0];
    end
  end

  // Three-row window of the old board; row 0 is kept for the torus wrap
  // because it is overwritten before the last row is computed.
  always_ff @(posedge clk) begin
    if (arr_vld) begin
      win_prev <= win_cur;
      win_cur  <= win_next;
      win_next <= feed;
      if (arr_idx == CW'(1)) begin
        row0 <= rd_data;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == lcab_pkg::ST_DONE) && out_free) begin
      out_valid  <= 1'b1;
      cell_alive <= res_alive;
      done_op    <= op_q;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- test/life_cellular_automaton_board_top_test.sv -----
module life_cellular_automaton_board_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  // The block leaves code 3 of func unused. The register port has one index
  // past the last register, which the block must ignore.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] REG_NONE = 2'd3;
  localparam int BOARD_SIDE = 64;

  // One result beat as the block should present it.
  typedef struct packed {
    logic       alive;
    logic [1:0] op;
  } cell_answer_t;

  // The scoreboard keeps its own board and rule settings. Every accepted
  // input beat is applied to that board at once, and the answer that the
  // block owes for it is queued. Result beats come out in order, so each one
  // is compared with the oldest queued answer.
  class life_board_scoreboard;
    logic [BOARD_SIDE-1:0]       board [BOARD_SIDE];
    logic                        wrap;
    logic [lcab_pkg::MASK_W-1:0] birth;
    logic [lcab_pkg::MASK_W-1:0] survive;
    cell_answer_t                answers_due [$];
    int                          errors;

    function new();
      foreach (board[r]) board[r] = '0;
      wrap = 1'b0;
      birth = 9'd8;
      survive = 9'd12;
      errors = 0;
    endfunction

    function void apply_reg(logic [1:0] idx, logic [lcab_pkg::MASK_W-1:0] value);
      case (idx)
        lcab_pkg::REG_WRAP: wrap = value[0];
        lcab_pkg::REG_BIRTH: birth = value;
        lcab_pkg::REG_SURVIVE: survive = value;
        default: ;
      endcase
    endfunction

    // All cells change together, so every count is taken from a copy of the
    // board as it stood before the generation.
    function void next_generation();
      logic [BOARD_SIDE-1:0]       prev [BOARD_SIDE];
      logic [lcab_pkg::MASK_W-1:0] rule;
      int                          nr;
      int                          nc;
      int                          live;
      prev = board;
      for (int r = 0; r < BOARD_SIDE; r++) begin
        for (int c = 0; c < BOARD_SIDE; c++) begin
          live = 0;
          for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
              if (dr != 0 || dc != 0) begin
                nr = r + dr;
                nc = c + dc;
                if (wrap) begin
                  nr = (nr + BOARD_SIDE) % BOARD_SIDE;
                  nc = (nc + BOARD_SIDE) % BOARD_SIDE;
                end
                if (nr >= 0 && nr < BOARD_SIDE && nc >= 0 && nc < BOARD_SIDE)
                  live += int'(prev[nr][nc]);
              end
            end
          end
          rule = prev[r][c] ? survive : birth;
          board[r][c] = rule[live];
        end
      end
    endfunction

    function void note_input(logic [1:0] f, logic [5:0] x, logic [5:0] y);
      cell_answer_t due;
      due.alive = 1'b0;
      due.op = f;
      case (f)
        lcab_pkg::OP_TOGGLE: begin
          board[x][y] = ~board[x][y];
          due.alive = board[x][y];
        end
        lcab_pkg::OP_READ: due.alive = board[x][y];
        lcab_pkg::OP_ADVANCE: next_generation();
        default: ;
      endcase
      answers_due.push_back(due);
    endfunction

    function int pending();
      return answers_due.size();
    endfunction

    task report_mismatch(string what);
      if (errors < 50) $display("%0t ns: mismatch: %s", $time, what);
      errors++;
    endtask

    task check_result(logic alive, logic [1:0] op);
      cell_answer_t due;
      if (answers_due.size() == 0) begin
        report_mismatch($sformatf("result beat (alive %0b, op %0d) with nothing owed",
                                  alive, op));
      end else begin
        due = answers_due.pop_front();
        if (op !== due.op)
          report_mismatch($sformatf("done_op %0d, expected %0d", op, due.op));
        if (alive !== due.alive)
          report_mismatch($sformatf("cell_alive %0b, expected %0b for op %0d",
                                    alive, due.alive, due.op));
      end
    endtask
  endclass

  // Every input of the block starts at a known value at time zero.
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] func = lcab_pkg::OP_READ;
  logic [5:0] col_x = '0;
  logic [5:0] row_y = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       cell_alive;
  logic [1:0] done_op;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = lcab_pkg::REG_WRAP;
  logic [8:0] cfg_wdata = '0;

  // Idling odds, in percent, for the sender and the receiver. The main
  // sequence sets them per phase. hold_cycles makes the receiver hold off
  // for that many cycles in a row, counted down by the receiver itself.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  life_board_scoreboard sb = new();

  life_cellular_automaton_board_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .col_x     (col_x),
    .row_y     (row_y),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cell_alive(cell_alive),
    .done_op   (done_op),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Offer one input beat and return at the edge where it is taken. Valid
  // stays high after acceptance; it only drops before a gap in the beats
  // or while draining, so it never gets two assignments in one step.
  task automatic send_item(logic [1:0] f, logic [5:0] x, logic [5:0] y);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    col_x <= x;
    row_y <= y;
    do @(posedge clk); while (!in_ready);
    sb.note_input(f, x, y);
  endtask

  // Most coordinates fall in an 8 x 8 window at base, so that toggles build
  // up live patterns and reads land on them; the window wraps around the
  // board edges when base is near them. The rest go anywhere.
  function automatic logic [5:0] pick_coord(logic [5:0] base);
    if ($urandom_range(0, 9) < 7) return base + 6'($urandom_range(0, 7));
    return 6'($urandom_range(0, 63));
  endfunction

  task automatic send_random_item(logic [5:0] row_base, logic [5:0] col_base);
    int         roll;
    logic [1:0] f;
    roll = $urandom_range(0, 99);
    if (roll < 48) f = lcab_pkg::OP_TOGGLE;
    else if (roll < 73) f = lcab_pkg::OP_READ;
    else if (roll < 94) f = lcab_pkg::OP_ADVANCE;
    else f = OP_UNUSED;
    send_item(f, pick_coord(row_base), pick_coord(col_base));
  endtask

  // Stop offering and wait until every owed result has come back. Since each
  // beat yields exactly one result, the block is idle after that.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
  endtask

  // Register writes go out back to back; the caller lowers cfg_we after the
  // last one.
  task automatic write_reg(logic [1:0] idx, logic [8:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.apply_reg(idx, value);
  endtask

  task automatic write_rule(logic w, logic [8:0] b, logic [8:0] s);
    write_reg(lcab_pkg::REG_WRAP, {8'd0, w});
    write_reg(lcab_pkg::REG_BIRTH, b);
    write_reg(lcab_pkg::REG_SURVIVE, s);
    cfg_we <= 1'b0;
  endtask

  // Receiver: checks each result beat at the edge it is taken, then decides
  // ready for the next cycle, either from the hold-off count or at random.
  initial begin
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_result(cell_alive, done_op);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    logic       w;
    logic [8:0] b;
    logic [8:0] s;
    logic [5:0] row_base;
    logic [5:0] col_base;
    int         mode;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset rule (birth on 3, survive on 2 or 3), bounded
    // edges. The board must come up empty; then the four corners are set,
    // the unused operation code must change nothing and answer zero even on
    // a live cell, and the corner at 0, 0 is cleared again.
    send_item(lcab_pkg::OP_READ, 6'd0, 6'd0);
    send_item(lcab_pkg::OP_TOGGLE, 6'd0, 6'd0);
    send_item(lcab_pkg::OP_TOGGLE, 6'd63, 6'd63);
    send_item(lcab_pkg::OP_TOGGLE, 6'd0, 6'd63);
    send_item(lcab_pkg::OP_TOGGLE, 6'd63, 6'd0);
    send_item(lcab_pkg::OP_READ, 6'd63, 6'd63);
    send_item(OP_UNUSED, 6'd63, 6'd63);
    send_item(lcab_pkg::OP_TOGGLE, 6'd0, 6'd0);

    // A horizontal blinker away from the board edges.
    send_item(lcab_pkg::OP_TOGGLE, 6'd10, 6'd9);
    send_item(lcab_pkg::OP_TOGGLE, 6'd10, 6'd10);
    send_item(lcab_pkg::OP_TOGGLE, 6'd10, 6'd11);

    // A write to the index past the last register must be ignored, and a
    // wrap write with only upper bits set must leave the edges bounded.
    wait_drained();
    write_reg(REG_NONE, 9'h1FF);
    write_reg(lcab_pkg::REG_WRAP, 9'h1FE);
    cfg_we <= 1'b0;

    // The blinker turns vertical and back; the three lone corners die
    // because nothing outside the board counts.
    send_item(lcab_pkg::OP_ADVANCE, 6'd0, 6'd0);
    send_item(lcab_pkg::OP_READ, 6'd9, 6'd10);
    send_item(lcab_pkg::OP_READ, 6'd10, 6'd9);
    send_item(lcab_pkg::OP_READ, 6'd11, 6'd10);
    send_item(lcab_pkg::OP_ADVANCE, 6'd63, 6'd63);
    send_item(lcab_pkg::OP_READ, 6'd10, 6'd9);
    send_item(lcab_pkg::OP_READ, 6'd63, 6'd63);

    // With wraparound the three corners touch each other and the empty
    // fourth corner, which therefore is born.
    wait_drained();
    write_reg(lcab_pkg::REG_WRAP, 9'h1FF);
    cfg_we <= 1'b0;
    send_item(lcab_pkg::OP_TOGGLE, 6'd0, 6'd63);
    send_item(lcab_pkg::OP_TOGGLE, 6'd63, 6'd0);
    send_item(lcab_pkg::OP_TOGGLE, 6'd63, 6'd63);
    send_item(lcab_pkg::OP_ADVANCE, 6'd0, 6'd0);
    send_item(lcab_pkg::OP_READ, 6'd0, 6'd0);
    send_item(lcab_pkg::OP_READ, 6'd63, 6'd63);

    // Random part: seven phases of seventeen beats. Each phase starts from an
    // idle block with a new rule, including the all-zero and all-one masks,
    // and its own idling pattern.
    for (int p = 0; p < 7; p++) begin
      wait_drained();
      row_base = 6'($urandom_range(0, 63));
      col_base = 6'($urandom_range(0, 63));
      case (p)
        0: begin
          w = 1'b0; b = 9'd8; s = 9'd12;
          send_idle_pct = 0; recv_stall_pct = 0;
        end
        1: begin
          // Window straddles the board corner, where wraparound matters.
          w = 1'b1; b = 9'd8; s = 9'd12;
          send_idle_pct = 78; recv_stall_pct = 0;
          row_base = 6'd60;
          col_base = 6'd60;
        end
        2: begin
          w = 1'b1; b = 9'd0; s = 9'd0;
          send_idle_pct = 0; recv_stall_pct = 78;
        end
        3: begin
          w = 1'b0; b = 9'h1FF; s = 9'h1FF;
          send_idle_pct = 31; recv_stall_pct = 31;
        end
        4: begin
          w = 1'b1; b = 9'($urandom_range(0, 511)); s = 9'($urandom_range(0, 511));
          send_idle_pct = 0; recv_stall_pct = 0;
        end
        default: begin
          w = 1'($urandom_range(0, 1));
          b = 9'($urandom_range(0, 511));
          s = 9'($urandom_range(0, 511));
          // Birth on zero neighbors fills the whole board; keep it rare.
          if ($urandom_range(0, 3) != 0) b[0] = 1'b0;
          mode = (p == 5) ? 3 : $urandom_range(0, 3);
          send_idle_pct = (mode == 1 || mode == 3) ? ((mode == 3) ? 31 : 78) : 0;
          recv_stall_pct = (mode == 2 || mode == 3) ? ((mode == 3) ? 31 : 78) : 0;
        end
      endcase
      write_rule(w, b, s);

      // The receiver holds off long enough for the block to fill up and
      // drop in_ready while beats keep being offered.
      if (p == 4) hold_cycles = 300;

      for (int i = 0; i < 17; i++) begin
        // Halfway through one phase the sender pauses until the block has
        // handed back everything it owes.
        if (p == 5 && i == 8) wait_drained();
        send_random_item(row_base, col_base);
      end
    end

    // Wait for the last results, then a little over one advance more to
    // catch any beat the block should not have produced.
    wait_drained();
    repeat (80) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // The watchdog stops the run with a failure message if it hangs.
  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/lcab_pkg.sv
rtl/lcab_board_mem.sv
rtl/lcab_row_rule.sv
rtl/life_cellular_automaton_board_top.sv
test/life_cellular_automaton_board_top_test.sv
